>>> design/assert_macros.svh
// assertion macros used by the port-level checker
// each macro expects clk and rst_n to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define NAS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define NAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define NAS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/nas_pkg.sv
// types and constants of the nesting-aware argument scanner
// no dependencies
`default_nettype none

package nas_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [1:0] KIND_COPY = 2'd0;
  localparam logic [1:0] KIND_TERM = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_RPAREN     = 2'd1;
  localparam logic [1:0] ERR_RBRACK     = 2'd2;
  localparam logic [1:0] ERR_INCOMPLETE = 2'd3;

  localparam logic [2:0] REG_TERM_COUNT  = 3'd0;
  localparam logic [2:0] REG_TERM_CHAR_A = 3'd1;
  localparam logic [2:0] REG_TERM_CHAR_B = 3'd2;
  localparam logic [2:0] REG_TERM_CHAR_C = 3'd3;
  localparam logic [2:0] REG_TERM_CHAR_D = 3'd4;

  localparam int NUM_TERMS = 4;

  typedef struct packed {
    logic [2:0]                term_count;
    logic [NUM_TERMS-1:0][7:0] term_char;
  } nas_cfg_t;

  typedef struct packed {
    logic [1:0] error_code;
    logic [1:0] result_kind;
    logic [7:0] out_char;
  } nas_result_t;

endpackage

`default_nettype wire

>>> design/nesting_aware_argument_scanner_unit.sv
// Nesting-aware argument scanner: takes one character per item and copies
// an argument out of the stream, ending it on a semicolon outside quotes,
// on a configured terminator at nesting depth zero outside quotes, or on
// string end. Spaces and tabs give no result. One item is accepted every
// clock while the output is not stalled; the item waits in the input
// register while the combinational scan step reads the nesting state,
// and its result then loads into the result register. Both registers
// advance together whenever the result register is empty or being taken, so
// a stalled consumer holds one item in each stage. The user must write
// configuration only while the block is idle; the block does not enforce it.
// depends on nas_pkg, nas_cfg_regs, nas_scan_core, nas_out_stage
`default_nettype none

module nesting_aware_argument_scanner_unit
  import nas_pkg::*;
#(
  parameter int DEPTH_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_code
  input  wire logic       in_tuser,   // [0] end_mark
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic [3:0]      out_tuser,  // [1:0] result_kind, [3:2] error_code
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  nas_cfg_t    cfg;
  nas_result_t res;
  nas_result_t out_res;
  logic        res_push;
  logic        out_room;

  nas_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  nas_scan_core #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_char   (in_tdata),
    .in_end    (in_tuser),
    .out_room  (out_room),
    .res_push  (res_push),
    .res       (res)
  );

  nas_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_push   (res_push),
    .res        (res),
    .out_room   (out_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.out_char;
  assign out_tuser = {out_res.error_code, out_res.result_kind};

endmodule

`default_nettype wire

>>> design/nas_cfg_regs.sv
// configuration registers: terminator count and terminator characters
// depends on nas_pkg
`default_nettype none

module nas_cfg_regs
  import nas_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output nas_cfg_t        cfg
);

  nas_cfg_t cfg_r;
  nas_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_TERM_COUNT:  cfg_nxt.term_count   = cfg_wdata[2:0];
        REG_TERM_CHAR_A: cfg_nxt.term_char[0] = cfg_wdata;
        REG_TERM_CHAR_B: cfg_nxt.term_char[1] = cfg_wdata;
        REG_TERM_CHAR_C: cfg_nxt.term_char[2] = cfg_wdata;
        REG_TERM_CHAR_D: cfg_nxt.term_char[3] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.term_count   <= 3'd1;
      cfg_r.term_char[0] <= CH_COMMA;
      cfg_r.term_char[1] <= CH_NUL;
      cfg_r.term_char[2] <= CH_NUL;
      cfg_r.term_char[3] <= CH_NUL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> design/nas_scan_core.sv
// input register, nesting state and the per-character scan step
// depends on nas_pkg
`default_nettype none

module nas_scan_core
  import nas_pkg::*;
#(
  parameter int DEPTH_BITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire nas_cfg_t   cfg,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_char,
  input  wire logic       in_end,
  input  wire logic       out_room,
  output logic            res_push,
  output nas_result_t     res
);

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

  logic                  in_valid_r, in_valid_nxt;
  logic [7:0]            in_char_r;
  logic                  in_end_r;
  logic [DEPTH_BITS-1:0] paren_r, paren_nxt;
  logic [DEPTH_BITS-1:0] brack_r, brack_nxt;
  logic                  squote_r, squote_nxt;
  logic                  dquote_r, dquote_nxt;

  logic       advance;
  logic       accept;
  logic       quoted;
  logic       is_term;
  logic       open_err;
  logic       has_res;
  logic [2:0] term_n;

  assign advance   = in_valid_r && out_room;
  assign in_tready = !in_valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  // counts above four behave as four
  assign term_n = (cfg.term_count > 3'd4) ? 3'd4 : cfg.term_count;

  always_comb begin
    is_term = 1'b0;
    for (int i = 0; i < NUM_TERMS; i++) begin
      if (term_n > 3'(i) && cfg.term_char[i] == in_char_r) begin
        is_term = 1'b1;
      end
    end
    if (in_char_r == CH_NUL) begin
      is_term = 1'b0;
    end
  end

  assign quoted   = squote_r || dquote_r;
  assign open_err = (paren_r != '0) || (brack_r != '0) || squote_r || dquote_r;

  always_comb begin
    paren_nxt       = paren_r;
    brack_nxt       = brack_r;
    squote_nxt      = squote_r;
    dquote_nxt      = dquote_r;
    has_res         = 1'b1;
    res.out_char    = in_char_r;
    res.result_kind = KIND_COPY;
    res.error_code  = ERR_NONE;
    if (in_end_r || in_char_r == CH_NUL) begin
      res.out_char    = CH_NUL;
      res.result_kind = KIND_END;
      res.error_code  = open_err ? ERR_INCOMPLETE : ERR_NONE;
      paren_nxt       = '0;
      brack_nxt       = '0;
      squote_nxt      = 1'b0;
      dquote_nxt      = 1'b0;
    end else if (in_char_r == CH_SPACE || in_char_r == CH_TAB) begin
      has_res = 1'b0;
    end else if (!quoted && (in_char_r == CH_SEMI ||
                 (is_term && paren_r == '0 && brack_r == '0))) begin
      res.result_kind = KIND_TERM;
      res.error_code  = open_err ? ERR_INCOMPLETE : ERR_NONE;
      paren_nxt       = '0;
      brack_nxt       = '0;
      squote_nxt      = 1'b0;
      dquote_nxt      = 1'b0;
    end else begin
      case (in_char_r)
        CH_LPAREN: begin
          if (!quoted && paren_r != DEPTH_MAX) paren_nxt = paren_r + DEPTH_ONE;
        end
        CH_RPAREN: begin
          if (!quoted) begin
            if (paren_r == '0) res.error_code = ERR_RPAREN;
            else               paren_nxt = paren_r - DEPTH_ONE;
          end
        end
        CH_LBRACK: begin
          if (!quoted && brack_r != DEPTH_MAX) brack_nxt = brack_r + DEPTH_ONE;
        end
        CH_RBRACK: begin
          if (!quoted) begin
            if (brack_r == '0) res.error_code = ERR_RBRACK;
            else               brack_nxt = brack_r - DEPTH_ONE;
          end
        end
        CH_SQUOTE: begin
          if (!dquote_r) squote_nxt = !squote_r;
        end
        CH_DQUOTE: begin
          if (!squote_r) dquote_nxt = !dquote_r;
        end
        default: ;
      endcase
    end
  end

  assign res_push = advance && has_res;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept)       in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      paren_r    <= '0;
      brack_r    <= '0;
      squote_r   <= 1'b0;
      dquote_r   <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (advance) begin
        paren_r  <= paren_nxt;
        brack_r  <= brack_nxt;
        squote_r <= squote_nxt;
        dquote_r <= dquote_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_char_r <= in_char;
      in_end_r  <= in_end;
    end
  end

endmodule

`default_nettype wire

>>> design/nas_out_stage.sv
// result register in front of the output stream
// depends on nas_pkg
`default_nettype none

module nas_out_stage
  import nas_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        res_push,
  input  wire nas_result_t res,
  output logic             out_room,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output nas_result_t      out_res
);

  logic        out_valid_r, out_valid_nxt;
  nas_result_t res_r;

  assign out_room = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_push)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;

endmodule

`default_nettype wire

>>> design/nas_checker.sv
// port-level checks of the argument scanner, bound to the top level
// depends on nas_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module nas_checker
  import nas_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic [3:0] out_tuser
);

  logic        waiting;
  logic [11:0] out_item;
  logic [1:0]  kind;
  logic [1:0]  err;

  assign waiting  = out_tvalid && !out_tready;
  assign out_item = {out_tuser, out_tdata};
  assign kind     = out_tuser[1:0];
  assign err      = out_tuser[3:2];

  // a waiting result holds still
  `NAS_ASSERT_NEXT(a_out_hold, waiting, out_tvalid && $stable(out_item))
  // nothing is shown right after reset
  `NAS_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid)
  // only the three result kinds appear
  `NAS_ASSERT_NOW(a_kind_legal, out_tvalid, kind == KIND_COPY || kind == KIND_TERM || kind == KIND_END)
  // string end carries a zero character
  `NAS_ASSERT_NOW(a_end_char, out_tvalid && kind == KIND_END, out_tdata == CH_NUL)
  // unmatched closers are only flagged on copied characters
  `NAS_ASSERT_NOW(a_closer_err, out_tvalid && (err == ERR_RPAREN || err == ERR_RBRACK), kind == KIND_COPY)

endmodule

bind nesting_aware_argument_scanner_unit nas_checker u_nas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
